/* rtl/core/benes_network_router_unit_macros.svh */
// Assertion macros used by the Benes network router top level.
`ifndef BENES_NETWORK_ROUTER_UNIT_MACROS_SVH
`define BENES_NETWORK_ROUTER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent in one cycle implies consequent in the same cycle.
`define BNR_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Antecedent in one cycle implies consequent in the next cycle.
`define BNR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BNR_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define BNR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/core/bnr_pkg.sv */
// Shared types, constants and helper functions of the Benes network router.
package bnr_pkg;

    localparam int PORTS   = 8;
    localparam int COLUMNS = 5;
    localparam int LAYERS  = 3;
    localparam int PW      = 3;
    localparam int CW      = 3;
    localparam int LW      = 2;
    localparam int SWW     = 8;

    typedef enum logic [1:0] {
        MARK_NONE = 2'd0,
        MARK_UP   = 2'd1,
        MARK_DOWN = 2'd2
    } t_mark;

    localparam logic [1:0] SW_PARALLEL = 2'd0;
    localparam logic [1:0] SW_PERMUTE  = 2'd1;
    localparam logic [1:0] SW_UNUSED   = 2'd2;
    localparam logic [1:0] SW_CONFLICT = 2'd3;

    typedef struct packed {
        logic          v;
        logic [PW-1:0] port;
    } t_entry;

    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_STORE   = 3'd1,
        OP_SCAN    = 3'd2,
        OP_CHAIN_A = 3'd3,
        OP_CHAIN_B = 3'd4,
        OP_CHECK_C = 3'd5,
        OP_LAYER   = 3'd6,
        OP_OUT_ACK = 3'd7
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic scan_hit;
        logic k_last;
        logic a_end;
        logic b_end;
        logic c_go;
        logic layer_last;
        logic col_last;
    } t_sts;

    function automatic t_mark other_side(input t_mark m);
        t_mark r;
        case (m)
            MARK_UP:   r = MARK_DOWN;
            MARK_DOWN: r = MARK_UP;
            default:   r = m;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] pair_state(input t_mark a, input t_mark b);
        logic [1:0] r;
        if (a == MARK_NONE) begin
            if (b == MARK_NONE) r = SW_UNUSED;
            else r = (b == MARK_UP) ? SW_PERMUTE : SW_PARALLEL;
        end else if (a == MARK_UP) begin
            r = (b == MARK_UP) ? SW_CONFLICT : SW_PARALLEL;
        end else begin
            r = (b == MARK_DOWN) ? SW_CONFLICT : SW_PERMUTE;
        end
        return r;
    endfunction

    function automatic logic [SWW-1:0] column_word(input t_mark marks [PORTS]);
        logic [SWW-1:0] w;
        w = '0;
        for (int k = 0; k < PORTS / 2; k++) begin
            w[2*k +: 2] = pair_state(marks[2*k], marks[2*k+1]);
        end
        return w;
    endfunction

endpackage

/* rtl/core/bnr_ctrl.sv */
// Sequencer of the Benes network router: loads pairs, steps the routing, emits columns.
module bnr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_last_pair,
    input  logic          i_out_ready,
    input  bnr_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output bnr_pkg::t_cmd o_cmd
);
    import bnr_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_SCAN    = 7'b0000010,
        S_CHAIN_A = 7'b0000100,
        S_CHAIN_B = 7'b0001000,
        S_CHECK_C = 7'b0010000,
        S_LAYER   = 7'b0100000,
        S_OUT     = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    // Next state and the command for the datapath.
    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_STORE;
                    if (i_last_pair) n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.op = OP_SCAN;
                if (i_sts.scan_hit) n_state = S_CHAIN_A;
                else if (i_sts.k_last) n_state = S_LAYER;
            end
            S_CHAIN_A: begin
                o_cmd.op = OP_CHAIN_A;
                n_state  = i_sts.a_end ? S_CHECK_C : S_CHAIN_B;
            end
            S_CHAIN_B: begin
                o_cmd.op = OP_CHAIN_B;
                n_state  = i_sts.b_end ? S_CHECK_C : S_CHAIN_A;
            end
            S_CHECK_C: begin
                o_cmd.op = OP_CHECK_C;
                if (i_sts.c_go) n_state = S_CHAIN_A;
                else if (i_sts.k_last) n_state = S_LAYER;
                else n_state = S_SCAN;
            end
            S_LAYER: begin
                o_cmd.op = OP_LAYER;
                n_state  = i_sts.layer_last ? S_OUT : S_SCAN;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    o_cmd.op = OP_OUT_ACK;
                    if (i_sts.col_last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

endmodule

/* rtl/core/bnr_dpath.sv */
// Datapath of the Benes network router: maps, side marks, chain walker, column words.
module bnr_dpath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bnr_pkg::t_cmd          i_cmd,
    input  logic [bnr_pkg::PW-1:0] i_in_port,
    input  logic [bnr_pkg::PW-1:0] i_out_port,
    output bnr_pkg::t_sts          o_sts,
    output logic [bnr_pkg::CW-1:0] o_column_index,
    output logic [bnr_pkg::SWW-1:0] o_switch_states,
    output logic                   o_last_column
);
    import bnr_pkg::*;

    t_entry         r_route [PORTS], n_route [PORTS];
    t_entry         r_src   [PORTS], n_src   [PORTS];
    t_mark          r_im    [PORTS], n_im    [PORTS];
    t_mark          r_om    [PORTS], n_om    [PORTS];
    logic [SWW-1:0] r_set   [COLUMNS], n_set [COLUMNS];
    logic [PW-1:0]  r_k, n_k, r_cur, n_cur, r_s, n_s;
    t_mark          r_m, n_m, r_first, n_first;
    logic           r_second, n_second;
    logic [LW-1:0]  r_layer, n_layer;
    logic [CW-1:0]  r_col, n_col;

    // Port number inside a subnetwork of the next layer.
    function automatic logic [PW-1:0] sub_port(input logic [PW-1:0] x,
                                              input logic [LW-1:0] layer,
                                              input t_mark mark);
        logic [PW:0]   tot;
        logic [PW-1:0] mask;
        logic [PW-1:0] half;
        tot  = (PW+1)'(PORTS) >> layer;
        mask = PW'(tot - 1'b1);
        half = PW'(tot >> 1);
        return (x & ~mask) + ((x & mask) >> 1) + ((mark == MARK_DOWN) ? half : '0);
    endfunction

    // Addresses used by the chain walker.
    logic [PW-1:0] w_c, w_o, w_p, w_q;
    assign w_c = r_k ^ PW'(1);
    assign w_o = r_route[r_cur].port;
    assign w_p = w_o ^ PW'(1);
    assign w_q = r_s ^ PW'(1);

    assign o_sts.scan_hit   = r_route[r_k].v && (r_im[r_k] == MARK_NONE);
    assign o_sts.k_last     = (r_k == PW'(PORTS - 1));
    assign o_sts.a_end      = !r_src[w_p].v || (r_om[w_p] != MARK_NONE);
    assign o_sts.b_end      = !r_route[w_q].v || (r_im[w_q] != MARK_NONE);
    assign o_sts.c_go       = !r_second && r_route[w_c].v && (r_im[w_c] == MARK_NONE);
    assign o_sts.layer_last = (r_layer == LW'(LAYERS - 1));
    assign o_sts.col_last   = (r_col == CW'(COLUMNS - 1));

    assign o_column_index  = r_col;
    assign o_switch_states = r_set[r_col];
    assign o_last_column   = (r_col == CW'(COLUMNS - 1));

    // Next values of maps, marks and counters for each command.
    always_comb begin
        logic [PW-1:0] ii, jj, oo;
        n_route  = r_route;
        n_src    = r_src;
        n_im     = r_im;
        n_om     = r_om;
        n_set    = r_set;
        n_k      = r_k;
        n_cur    = r_cur;
        n_s      = r_s;
        n_m      = r_m;
        n_first  = r_first;
        n_second = r_second;
        n_layer  = r_layer;
        n_col    = r_col;
        ii = '0;
        jj = '0;
        oo = '0;
        case (i_cmd.op)
            OP_STORE: begin
                if (r_route[i_in_port].v) n_src[r_route[i_in_port].port].v = 1'b0;
                if (r_src[i_out_port].v) n_route[r_src[i_out_port].port].v = 1'b0;
                n_route[i_in_port] = '{v: 1'b1, port: i_out_port};
                n_src[i_out_port]  = '{v: 1'b1, port: i_in_port};
            end
            OP_SCAN: begin
                if (o_sts.scan_hit) begin
                    n_cur    = r_k;
                    n_m      = (r_im[w_c] == MARK_UP) ? MARK_DOWN : MARK_UP;
                    n_first  = n_m;
                    n_second = 1'b0;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            OP_CHAIN_A: begin
                n_im[r_cur] = r_m;
                if (r_om[w_o] == MARK_NONE) n_om[w_o] = r_m;
                if (!o_sts.a_end) begin
                    n_om[w_p] = other_side(r_m);
                    n_s       = r_src[w_p].port;
                end
            end
            OP_CHAIN_B: begin
                if (r_im[r_s] == MARK_NONE) n_im[r_s] = other_side(r_m);
                if (!o_sts.b_end) n_cur = w_q;
            end
            OP_CHECK_C: begin
                if (o_sts.c_go) begin
                    n_cur    = w_c;
                    n_m      = other_side(r_first);
                    n_second = 1'b1;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            OP_LAYER: begin
                n_set[CW'(r_layer)] = column_word(r_im);
                n_set[CW'(COLUMNS - 1) - CW'(r_layer)] = column_word(r_om);
                if (!o_sts.layer_last) begin
                    // Renumber the connections into the subnetworks.
                    for (int i = 0; i < PORTS; i++) begin
                        n_route[i] = '0;
                        n_src[i]   = '0;
                        n_im[i]    = MARK_NONE;
                        n_om[i]    = MARK_NONE;
                    end
                    for (int i = 0; i < PORTS; i++) begin
                        if (r_route[i].v) begin
                            oo = r_route[i].port;
                            ii = sub_port(PW'(i), r_layer, r_im[i]);
                            jj = sub_port(oo, r_layer, r_om[oo]);
                            n_route[ii] = '{v: 1'b1, port: jj};
                            n_src[jj]   = '{v: 1'b1, port: ii};
                        end
                    end
                    n_layer = r_layer + 1'b1;
                end
            end
            OP_OUT_ACK: begin
                n_col = r_col + 1'b1;
                if (o_sts.col_last) begin
                    for (int i = 0; i < PORTS; i++) begin
                        n_route[i] = '0;
                        n_src[i]   = '0;
                        n_im[i]    = MARK_NONE;
                        n_om[i]    = MARK_NONE;
                    end
                    n_col   = '0;
                    n_layer = '0;
                    n_k     = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // Control state and valid bits are cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PORTS; i++) begin
                r_route[i] <= '0;
                r_src[i]   <= '0;
                r_im[i]    <= MARK_NONE;
                r_om[i]    <= MARK_NONE;
            end
            r_k      <= '0;
            r_layer  <= '0;
            r_col    <= '0;
            r_second <= 1'b0;
        end else begin
            r_route  <= n_route;
            r_src    <= n_src;
            r_im     <= n_im;
            r_om     <= n_om;
            r_k      <= n_k;
            r_layer  <= n_layer;
            r_col    <= n_col;
            r_second <= n_second;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_set   <= n_set;
        r_cur   <= n_cur;
        r_s     <= n_s;
        r_m     <= n_m;
        r_first <= n_first;
    end

endmodule

/* rtl/core/benes_network_router_unit.sv */
// Top level of the Benes network router (8x8 network, looping algorithm).
// Connection pairs load one beat per cycle. The beat marked last_pair starts
// routing, during which no input beat is taken: for each of the three layers
// the sequencer scans the eight inputs for an unmarked one, walks the chain
// from it marking each connection, closes the chain (and opens a second one
// when the couple of the starting input is connected and unmarked), then
// writes the layer's column words and, except in the last layer, renumbers
// the connections. Five column beats follow, one per cycle while the sink
// is ready, after which the maps are clear and the next request may load.
module benes_network_router_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [bnr_pkg::PW-1:0]          i_in_port,
    input  logic [bnr_pkg::PW-1:0]          i_out_port,
    input  logic                            i_last_pair,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [bnr_pkg::CW-1:0]          o_column_index,
    output logic [bnr_pkg::SWW-1:0]         o_switch_states,
    output logic                            o_last_column
);
    import bnr_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    bnr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_last_pair (i_last_pair),
        .i_out_ready (i_ready),
        .i_sts       (w_sts),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .o_cmd       (w_cmd)
    );

    bnr_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_in_port       (i_in_port),
        .i_out_port      (i_out_port),
        .o_sts           (w_sts),
        .o_column_index  (o_column_index),
        .o_switch_states (o_switch_states),
        .o_last_column   (o_last_column)
    );

`include "benes_network_router_unit_macros.svh"

    // Loading and emitting never overlap.
    `BNR_ASSERT_SAME(a_no_overlap, i_clk, i_rst_n, o_valid, !o_ready)
    // A last pair starts routing, so loading stops.
    `BNR_ASSERT_NEXT(a_last_stops_load, i_clk, i_rst_n, i_valid && o_ready && i_last_pair, !o_ready)
    // After the final column beat the block loads again.
    `BNR_ASSERT_NEXT(a_back_to_load, i_clk, i_rst_n, o_valid && i_ready && o_last_column, o_ready && !o_valid)

endmodule

/* verif/tb_benes_network_router_unit.sv */
// Self-checking testbench for the Benes network router: random requests, column checks.
module tb_benes_network_router_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import bnr_pkg::*;

    typedef struct {
        logic [PW-1:0] in_port;
        logic [PW-1:0] out_port;
        logic          last;
        int            gap;
        bit            drain;
    } t_pair_item;

    typedef struct {
        logic [CW-1:0]  col;
        logic [SWW-1:0] states;
        logic           last;
    } t_column_beat;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [PW-1:0]     i_in_port;
    logic [PW-1:0]     i_out_port;
    logic              i_last_pair;
    logic              o_valid;
    logic              i_ready;
    logic [CW-1:0]     o_column_index;
    logic [SWW-1:0]    o_switch_states;
    logic              o_last_column;

    t_pair_item   pair_q[$];
    t_column_beat column_q[$];
    int           pairs_taken;
    int           columns_taken;
    int           requests_routed;
    int           errors;

    // Predictor state: the connection maps and the side marks of one layer.
    logic          fwd_v[PORTS];
    logic [PW-1:0] fwd_p[PORTS];
    logic          bwd_v[PORTS];
    logic [PW-1:0] bwd_p[PORTS];
    t_mark         in_mark[PORTS];
    t_mark         out_mark[PORTS];
    logic [SWW-1:0] col_words[COLUMNS];

    benes_network_router_unit dut (.*);

    // Clock, 10 ns period.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_mark flip_mark(t_mark m);
        if (m == MARK_UP) return MARK_DOWN;
        if (m == MARK_DOWN) return MARK_UP;
        return m;
    endfunction

    function automatic void clear_connections();
        for (int k = 0; k < PORTS; k++) begin
            fwd_v[k] = 1'b0; fwd_p[k] = '0;
            bwd_v[k] = 1'b0; bwd_p[k] = '0;
            in_mark[k] = MARK_NONE; out_mark[k] = MARK_NONE;
        end
    endfunction

    // A new pair displaces any earlier pair that used its input or its output.
    function automatic void record_pair(logic [PW-1:0] a, logic [PW-1:0] b);
        if (fwd_v[a]) bwd_v[fwd_p[a]] = 1'b0;
        if (bwd_v[b]) fwd_v[bwd_p[b]] = 1'b0;
        fwd_v[a] = 1'b1; fwd_p[a] = b;
        bwd_v[b] = 1'b1; bwd_p[b] = a;
    endfunction

    // Walk a chain from input i, alternating sides across switch couples.
    function automatic void walk_chain(int i, t_mark m);
        int o, p, s, q;
        for (int g = 0; g < PORTS; g++) begin
            in_mark[i] = m;
            o = fwd_p[i];
            if (out_mark[o] == MARK_NONE) out_mark[o] = m;
            p = o ^ 1;
            if (!bwd_v[p] || out_mark[p] != MARK_NONE) return;
            out_mark[p] = flip_mark(m);
            s = bwd_p[p];
            if (in_mark[s] == MARK_NONE) in_mark[s] = flip_mark(m);
            q = s ^ 1;
            if (!fwd_v[q] || in_mark[q] != MARK_NONE) return;
            i = q;
        end
    endfunction

    function automatic void mark_layer();
        int c;
        t_mark m;
        for (int k = 0; k < PORTS; k++) begin
            if (!fwd_v[k] || in_mark[k] != MARK_NONE) continue;
            c = k ^ 1;
            m = (in_mark[c] == MARK_UP) ? MARK_DOWN : MARK_UP;
            walk_chain(k, m);
            if (fwd_v[c] && in_mark[c] == MARK_NONE) walk_chain(c, flip_mark(m));
        end
    endfunction

    function automatic logic [1:0] switch_code(t_mark a, t_mark b);
        if (a == MARK_NONE) begin
            if (b == MARK_NONE) return SW_UNUSED;
            return (b == MARK_UP) ? SW_PERMUTE : SW_PARALLEL;
        end
        if (a == MARK_UP) return (b == MARK_UP) ? SW_CONFLICT : SW_PARALLEL;
        return (b == MARK_DOWN) ? SW_CONFLICT : SW_PERMUTE;
    endfunction

    function automatic logic [SWW-1:0] marks_to_word(bit use_out);
        logic [SWW-1:0] w;
        w = '0;
        for (int k = 0; k < PORTS / 2; k++) begin
            if (use_out) w[2*k +: 2] = switch_code(out_mark[2*k], out_mark[2*k+1]);
            else w[2*k +: 2] = switch_code(in_mark[2*k], in_mark[2*k+1]);
        end
        return w;
    endfunction

    function automatic int sub_index(int x, int total, t_mark m);
        int r;
        r = (x / total) * total + (x % total) / 2;
        if (m == MARK_DOWN) r += total / 2;
        return r;
    endfunction

    // Move every connection into its subnetwork numbering for the next layer.
    function automatic void renumber_ports(int total);
        logic          nfv[PORTS];
        logic [PW-1:0] nfp[PORTS];
        logic          nbv[PORTS];
        logic [PW-1:0] nbp[PORTS];
        int ii, jj;
        for (int k = 0; k < PORTS; k++) begin
            nfv[k] = 1'b0; nfp[k] = '0; nbv[k] = 1'b0; nbp[k] = '0;
        end
        for (int k = 0; k < PORTS; k++) begin
            if (!fwd_v[k]) continue;
            ii = sub_index(k, total, in_mark[k]);
            jj = sub_index(fwd_p[k], total, out_mark[fwd_p[k]]);
            nfv[ii] = 1'b1; nfp[ii] = jj[PW-1:0];
            nbv[jj] = 1'b1; nbp[jj] = ii[PW-1:0];
        end
        for (int k = 0; k < PORTS; k++) begin
            fwd_v[k] = nfv[k]; fwd_p[k] = nfp[k];
            bwd_v[k] = nbv[k]; bwd_p[k] = nbp[k];
            in_mark[k] = MARK_NONE; out_mark[k] = MARK_NONE;
        end
    endfunction

    // Route all layers and queue the five column words that should follow.
    function automatic void route_request();
        t_column_beat cb;
        for (int layer = 1; layer <= LAYERS; layer++) begin
            mark_layer();
            col_words[layer-1] = marks_to_word(1'b0);
            col_words[COLUMNS-layer] = marks_to_word(1'b1);
            if (layer < LAYERS) renumber_ports(PORTS >> (layer - 1));
        end
        for (int c = 0; c < COLUMNS; c++) begin
            cb.col = c[CW-1:0];
            cb.states = col_words[c];
            cb.last = (c == COLUMNS - 1);
            column_q.push_back(cb);
        end
        clear_connections();
    endfunction

    function automatic void add_pair(int a, int b, bit last, int gap, bit drain);
        t_pair_item it;
        it.in_port = a[PW-1:0];
        it.out_port = b[PW-1:0];
        it.last = last;
        it.gap = gap;
        it.drain = drain;
        pair_q.push_back(it);
    endfunction

    // Random partial permutation of n connections; when noisy, stray random pairs are mixed in.
    function automatic void add_request(int n, bit noisy);
        int ins[PORTS];
        int outs[PORTS];
        int j, t, gap;
        for (int k = 0; k < PORTS; k++) begin
            ins[k] = k; outs[k] = k;
        end
        for (int k = PORTS - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            t = ins[k]; ins[k] = ins[j]; ins[j] = t;
            j = $urandom_range(0, k);
            t = outs[k]; outs[k] = outs[j]; outs[j] = t;
        end
        for (int k = 0; k < n; k++) begin
            gap = (pair_q.size() >= 150 && pair_q.size() < 200) ? 0 : $urandom_range(0, 19);
            if (noisy && $urandom_range(0, 2) == 0)
                add_pair($urandom_range(0, 7), $urandom_range(0, 7), 1'b0, gap, 1'b0);
            add_pair(ins[k], outs[k], k == n - 1, gap, 1'b0);
        end
    endfunction

    // Stimulus: directed requests first, then random ones.
    initial begin
        // Full identity, then full reversal.
        for (int k = 0; k < PORTS; k++) add_pair(k, k, k == PORTS - 1, 0, 1'b0);
        for (int k = 0; k < PORTS; k++) add_pair(k, 7 - k, k == PORTS - 1, 3, 1'b0);
        // A single connection at the port extremes.
        add_pair(0, 7, 1'b1, 1, 1'b0);
        add_pair(7, 0, 1'b1, 0, 1'b0);
        // Repeated input port, then repeated output port.
        add_pair(2, 5, 1'b0, 0, 1'b0);
        add_pair(2, 1, 1'b0, 0, 1'b0);
        add_pair(6, 1, 1'b0, 0, 1'b0);
        add_pair(3, 4, 1'b1, 0, 1'b0);
        // Hold off the next request until all columns have come back.
        add_pair(4, 6, 1'b0, 0, 1'b1);
        add_pair(5, 7, 1'b1, 0, 1'b0);
        while (pair_q.size() < 370) begin
            if ($urandom_range(0, 9) < 7) add_request($urandom_range(1, 8), 1'b0);
            else add_request($urandom_range(1, 8), 1'b1);
        end
    end

    // Reset asserted at start, released at a falling edge.
    initial begin
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    // Monitor: count input beats, predict, and check column beats.
    initial begin
        pairs_taken = 0; columns_taken = 0; requests_routed = 0; errors = 0;
        clear_connections();
    end

    always @(posedge i_clk) begin
        t_column_beat cb;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                record_pair(i_in_port, i_out_port);
                if (i_last_pair) begin
                    route_request();
                    requests_routed <= requests_routed + 1;
                end
                pairs_taken <= pairs_taken + 1;
            end
            if (o_valid && i_ready) begin
                columns_taken <= columns_taken + 1;
                if (column_q.size() == 0) begin
                    $display("%0t: column beat with nothing expected: col %0d states %h",
                             $time, o_column_index, o_switch_states);
                    errors++;
                end else begin
                    cb = column_q.pop_front();
                    if (o_column_index !== cb.col || o_switch_states !== cb.states
                        || o_last_column !== cb.last) begin
                        $display({"%0t: mismatch: expected col %0d states %h last %b, ",
                                  "got col %0d states %h last %b"},
                                 $time, cb.col, cb.states, cb.last,
                                 o_column_index, o_switch_states, o_last_column);
                        errors++;
                    end
                end
            end
        end
    end

    // Driver: presents queued pairs at falling edges, each after its queued gap.
    int  pairs_seen;
    int  send_wait;
    initial begin
        i_valid = 1'b0; i_in_port = '0; i_out_port = '0; i_last_pair = 1'b0;
        pairs_seen = 0; send_wait = 0;
    end

    always @(negedge i_clk) begin
        bit v;
        t_pair_item it;
        v = i_valid;
        if (pairs_taken != pairs_seen) begin
            pairs_seen = pairs_taken;
            v = 1'b0;
        end
        if (i_rst_n && !v && pair_q.size() > 0) begin
            if (send_wait < pair_q[0].gap) begin
                send_wait++;
            end else if (!pair_q[0].drain || column_q.size() == 0) begin
                it = pair_q.pop_front();
                send_wait = 0;
                v = 1'b1;
                i_in_port <= it.in_port;
                i_out_port <= it.out_port;
                i_last_pair <= it.last;
            end
        end
        i_valid <= v;
    end

    // Sink: random stall before each column beat, with one stretch of none.
    int columns_seen;
    int recv_wait;
    initial begin
        i_ready = 1'b0;
        columns_seen = 0;
        recv_wait = 0;
    end

    always @(negedge i_clk) begin
        if (columns_taken != columns_seen) begin
            columns_seen = columns_taken;
            recv_wait = (columns_taken >= 100 && columns_taken < 160) ? 0 : $urandom_range(0, 19);
        end
        if (recv_wait > 0) begin
            recv_wait--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // End of run: drain, let the block settle, then report.
    initial begin
        wait (i_rst_n);
        wait (pair_q.size() == 0 && pairs_taken == pairs_seen && !i_valid);
        wait (column_q.size() == 0);
        repeat (100) @(posedge i_clk);
        $display("Routed %0d requests from %0d connection beats; checked %0d column beats.",
                 requests_routed, pairs_taken, columns_taken);
        if (errors == 0 && column_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #5ms;
        $display("Timeout with %0d column beats outstanding.", column_q.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
